// ===== rtl/imu_frame_yaw_calibrate_unwrap_assert.svh =====
// assertion macros for the yaw calibrate / unwrap block
// expects clk and arst_n in the scope of the module that uses them
`ifndef IMU_FRAME_YAW_CALIBRATE_UNWRAP_ASSERT_SVH
`define IMU_FRAME_YAW_CALIBRATE_UNWRAP_ASSERT_SVH

// property checked at every edge outside reset
`define IFYU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition in the cycle after a trigger
`define IFYU_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/ifyu_pkg.sv =====
// shared types and constants for the yaw calibrate / unwrap block
// no dependencies
package ifyu_pkg;

	localparam int unsigned SUM_W = 23;
	localparam int unsigned ANG_W = 16;
	localparam logic signed [ANG_W-1:0] TURN_MAX = 16'sh7fff;
	localparam logic signed [ANG_W-1:0] TURN_MIN = 16'sh8001;

	typedef logic signed [ANG_W-1:0] sample_t;

	typedef struct packed {
		logic    frame_valid;
		sample_t accel_x_raw;
		sample_t accel_y_raw;
		sample_t accel_z_raw;
		sample_t rate_x_raw;
		sample_t rate_y_raw;
		sample_t rate_z_raw;
		sample_t roll_ang;
		sample_t pitch_ang;
		sample_t yaw_raw;
		sample_t die_temp;
	} frame_t;

	typedef struct packed {
		logic               ready_res;
		sample_t            body_roll;
		sample_t            body_pitch;
		sample_t            body_yaw;
		sample_t            body_rate_x;
		sample_t            body_rate_y;
		sample_t            body_rate_z;
		sample_t            body_accel_x;
		sample_t            body_accel_y;
		sample_t            body_accel_z;
		sample_t            temperature;
		logic signed [31:0] yaw_multi;
	} result_t;

	typedef struct packed {
		logic    run;
		logic    busy;
		sample_t offset;
		logic    seed;
		sample_t seed_yaw;
	} calib_stat_t;

	typedef struct packed {
		sample_t            body_yaw;
		logic signed [31:0] yaw_multi;
	} unwrap_res_t;

endpackage

// ===== rtl/ifyu_calib.sv =====
// yaw offset calibration: sums raw yaw, then divides by the sample count
// through a reciprocal multiply; depends on ifyu_pkg
module ifyu_calib #(
	parameter int unsigned CALIB_SAMPLES = 100
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  ifyu_pkg::sample_t    yaw_raw,
	output ifyu_pkg::calib_stat_t stat
);

	localparam int unsigned CNT_W = $clog2(CALIB_SAMPLES + 1);
	localparam int unsigned SH    = ifyu_pkg::SUM_W + $clog2(CALIB_SAMPLES);
	localparam int unsigned MUL_W = ifyu_pkg::SUM_W + 2;
	localparam int unsigned PRD_W = ifyu_pkg::SUM_W + MUL_W;
	localparam logic [63:0] RECIP =
		((64'd1 << SH) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES);
	localparam logic [ifyu_pkg::SUM_W-1:0] BIAS =
		ifyu_pkg::SUM_W'(32768 * CALIB_SAMPLES);

	typedef enum logic [1:0] {
		ST_CAL,
		ST_MUL,
		ST_FIN,
		ST_RUN
	} state_t;

	state_t                      state_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [ifyu_pkg::SUM_W-1:0]  sum_q;
	ifyu_pkg::sample_t           last_q;
	logic [PRD_W-1:0]            prod_q;
	ifyu_pkg::sample_t           offset_q;

	logic [ifyu_pkg::SUM_W-1:0]  sum_nxt;
	logic [CNT_W-1:0]            cnt_nxt;
	ifyu_pkg::sample_t           off_nxt;

	// sum carries a bias of 32768 per sample so it never goes negative
	assign sum_nxt = sum_q + {{(ifyu_pkg::SUM_W - ifyu_pkg::ANG_W){yaw_raw[15]}}, yaw_raw};
	assign cnt_nxt = cnt_q + 1'b1;
	assign off_nxt = prod_q[SH +: ifyu_pkg::ANG_W] ^ 16'h8000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CAL;
			cnt_q    <= '0;
			sum_q    <= BIAS;
			last_q   <= '0;
			prod_q   <= '0;
			offset_q <= '0;
		end else begin
			unique case (state_q)
				ST_CAL: begin
					if (go) begin
						sum_q  <= sum_nxt;
						cnt_q  <= cnt_nxt;
						last_q <= yaw_raw;
						if (cnt_nxt == CNT_W'(CALIB_SAMPLES)) begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					prod_q  <= {{MUL_W{1'b0}}, sum_q} *
						{{ifyu_pkg::SUM_W{1'b0}}, RECIP[MUL_W-1:0]};
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					offset_q <= off_nxt;
					state_q  <= ST_RUN;
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_CAL;
				end
			endcase
		end
	end

	always_comb begin
		stat.run      = (state_q == ST_RUN);
		stat.busy     = (state_q == ST_MUL) || (state_q == ST_FIN);
		stat.offset   = offset_q;
		stat.seed     = (state_q == ST_FIN);
		stat.seed_yaw = last_q - off_nxt;
	end

endmodule

// ===== rtl/ifyu_unwrap.sv =====
// yaw offset removal and turn counting with saturation
// depends on ifyu_pkg
module ifyu_unwrap (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic                  seed,
	input  ifyu_pkg::sample_t     seed_yaw,
	input  ifyu_pkg::sample_t     offset,
	input  ifyu_pkg::sample_t     yaw_raw,
	output ifyu_pkg::unwrap_res_t res
);

	ifyu_pkg::sample_t  prev_q;
	ifyu_pkg::sample_t  turn_q;

	ifyu_pkg::sample_t  yaw;
	logic signed [16:0] delta;
	ifyu_pkg::sample_t  turn_nxt;

	assign yaw   = yaw_raw - offset;
	assign delta = {yaw[15], yaw} - {prev_q[15], prev_q};

	always_comb begin
		turn_nxt = turn_q;
		if (delta < -17'sd32768) begin
			if (turn_q != ifyu_pkg::TURN_MAX) begin
				turn_nxt = turn_q + 16'sd1;
			end
		end else if (delta > 17'sd32768) begin
			if (turn_q != ifyu_pkg::TURN_MIN) begin
				turn_nxt = turn_q - 16'sd1;
			end
		end
		res.body_yaw  = yaw;
		res.yaw_multi = {turn_nxt, 16'h0000} + {{16{yaw[15]}}, yaw};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			turn_q <= '0;
		end else begin
			if (seed) begin
				prev_q <= seed_yaw;
				turn_q <= '0;
			end else if (go) begin
				prev_q <= yaw;
				turn_q <= turn_nxt;
			end
		end
	end

endmodule

// ===== rtl/imu_frame_yaw_calibrate_unwrap.sv =====
// Sensor frame in, body-frame word out. One word is taken per clock while the result side
// does not stall and the offset is not being computed; the word is offered from the result
// register once its frame has passed the frame register, and frames flagged invalid are
// taken and dropped. The first CALIB_SAMPLES (1 to 128) valid frames each return a
// calibrating word of zeros; right after the last of them the frame register holds through
// ST_MUL and ST_FIN while the summed yaw goes through the reciprocal multiplier to give
// the offset, so at most one more frame is taken in that time. After that, yaw has the
// offset removed, turns across +-180 degrees are counted, and X/Y axes are swapped into body axes. Depends on ifyu_pkg.
module imu_frame_yaw_calibrate_unwrap #(
	parameter int unsigned CALIB_SAMPLES = 100
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frm_valid,
	output logic              frm_ready,
	input  ifyu_pkg::frame_t  frm,
	output logic              res_valid,
	input  logic              res_ready,
	output ifyu_pkg::result_t res
);

	logic                  s1_valid_q;
	ifyu_pkg::frame_t      frm_s1;
	logic                  res_valid_q;
	ifyu_pkg::result_t     res_s2;

	logic                  go;
	ifyu_pkg::calib_stat_t cstat;
	ifyu_pkg::unwrap_res_t ures;
	ifyu_pkg::result_t     res_nxt;

	assign go        = s1_valid_q && (!res_valid_q || res_ready) && !cstat.busy;
	assign frm_ready = !s1_valid_q || go;

	ifyu_calib #(
		.CALIB_SAMPLES(CALIB_SAMPLES)
	) u_calib (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.yaw_raw (frm_s1.yaw_raw),
		.stat    (cstat)
	);

	ifyu_unwrap u_unwrap (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go && cstat.run),
		.seed     (cstat.seed),
		.seed_yaw (cstat.seed_yaw),
		.offset   (cstat.offset),
		.yaw_raw  (frm_s1.yaw_raw),
		.res      (ures)
	);

	always_comb begin
		res_nxt = '0;
		if (cstat.run) begin
			res_nxt.ready_res    = 1'b1;
			res_nxt.body_roll    = frm_s1.pitch_ang;
			res_nxt.body_pitch   = frm_s1.roll_ang;
			res_nxt.body_yaw     = ures.body_yaw;
			res_nxt.body_rate_x  = frm_s1.rate_y_raw;
			res_nxt.body_rate_y  = frm_s1.rate_x_raw;
			res_nxt.body_rate_z  = frm_s1.rate_z_raw;
			res_nxt.body_accel_x = frm_s1.accel_y_raw;
			res_nxt.body_accel_y = frm_s1.accel_x_raw;
			res_nxt.body_accel_z = frm_s1.accel_z_raw;
			res_nxt.temperature  = frm_s1.die_temp;
			res_nxt.yaw_multi    = ures.yaw_multi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			frm_s1      <= '0;
			res_valid_q <= 1'b0;
			res_s2      <= '0;
		end else begin
			if (frm_valid && frm_ready && frm.frame_valid) begin
				s1_valid_q <= 1'b1;
				frm_s1     <= frm;
			end else if (go) begin
				s1_valid_q <= 1'b0;
			end
			if (go) begin
				res_valid_q <= 1'b1;
				res_s2      <= res_nxt;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_s2;

endmodule

// ===== rtl/ifyu_check.sv =====
// port-level checks for the yaw calibrate / unwrap block, bound to the top
// depends on ifyu_pkg and imu_frame_yaw_calibrate_unwrap_assert.svh
`include "imu_frame_yaw_calibrate_unwrap_assert.svh"

module ifyu_check (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input ifyu_pkg::result_t res
);

	logic ready_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_seen_q <= 1'b0;
		end else if (res_valid && res.ready_res) begin
			ready_seen_q <= 1'b1;
		end
	end

	`IFYU_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result word changed while stalled")
	`IFYU_ASSERT(a_cal_zero, (res_valid && !res.ready_res) |-> (res == '0), "calibrating word not all zero")
	`IFYU_ASSERT(a_ready_sticky, (ready_seen_q && res_valid) |-> res.ready_res, "calibrating word after ready")
	`IFYU_ASSERT(a_total_low, (res_valid && res.ready_res) |-> (res.yaw_multi[15:0] == res.body_yaw), "total yaw low half differs from body yaw")

endmodule

bind imu_frame_yaw_calibrate_unwrap ifyu_check u_ifyu_check (.*);

// ===== tb/tb.sv =====
// self-checking bench for imu_frame_yaw_calibrate_unwrap: directed frame table, then random
// frames with turn crossings; words are checked against a local predictor
// depends on ifyu_pkg and the rtl of imu_frame_yaw_calibrate_unwrap
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAL_FRAMES = 100;
	localparam int TURN_SAT = 32767;
	localparam int RAND_ITEMS = 1520;
	localparam int WATCHDOG_CYCLES = 2000;
	localparam int PLAN_ROWS = 20;

	typedef enum logic [1:0] {ROW_PLAIN, ROW_BODY, ROW_FILL} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic              valid;
		logic              zero_word;
		ifyu_pkg::sample_t yaw;
		ifyu_pkg::sample_t base;
	} row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              frm_valid = 1'b0;
	logic              frm_ready;
	ifyu_pkg::frame_t  frm = '0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	ifyu_pkg::result_t res;

	// predictor state
	bit                cal_done;
	int                cal_seen;
	int                yaw_acc;
	ifyu_pkg::sample_t yaw_bias;
	ifyu_pkg::sample_t prev_body;
	int                turns;
	int                turns_hi;
	int                turns_lo;

	ifyu_pkg::result_t body_due[$];
	bit                quiet;
	int                mismatches;
	int                frames_taken;
	int                frames_dropped;
	int                words_checked;
	int                idle_cycles;
	int                stall_left;

	// yaw of body rows is relative to the calibrated offset
	row_t plan [PLAN_ROWS] = '{
		'{ROW_PLAIN, 1'b0, 1'b1, 16'h7fff, 16'h7fff},
		'{ROW_PLAIN, 1'b0, 1'b1, 16'h8000, 16'h8000},
		'{ROW_PLAIN, 1'b1, 1'b1, 16'h7fff, 16'h7fff},
		'{ROW_PLAIN, 1'b1, 1'b1, 16'h8000, 16'h8000},
		'{ROW_PLAIN, 1'b1, 1'b1, 16'h7fff, 16'h0000},
		'{ROW_PLAIN, 1'b1, 1'b1, 16'h8000, 16'hffff},
		'{ROW_PLAIN, 1'b1, 1'b1, 16'h5555, 16'haaaa},
		'{ROW_PLAIN, 1'b1, 1'b1, 16'haaaa, 16'h5555},
		'{ROW_FILL,  1'b1, 1'b0, 16'h0000, 16'h0000},
		'{ROW_BODY,  1'b1, 1'b0, 16'h0000, 16'h7fff},
		'{ROW_BODY,  1'b1, 1'b0, 16'h7fff, 16'h8000},
		'{ROW_BODY,  1'b1, 1'b0, 16'h8000, 16'h0001},
		'{ROW_BODY,  1'b1, 1'b0, 16'h0000, 16'hfffe},
		'{ROW_BODY,  1'b1, 1'b0, 16'h8000, 16'h7ffe},
		'{ROW_BODY,  1'b1, 1'b0, 16'h0001, 16'h8001},
		'{ROW_BODY,  1'b1, 1'b0, 16'h8000, 16'h5555},
		'{ROW_BODY,  1'b0, 1'b0, 16'h0000, 16'h1234},
		'{ROW_BODY,  1'b1, 1'b0, 16'h7fff, 16'haaaa},
		'{ROW_BODY,  1'b1, 1'b0, 16'hffff, 16'h0000},
		'{ROW_BODY,  1'b1, 1'b0, 16'h7fff, 16'hffff}
	};

	imu_frame_yaw_calibrate_unwrap #(
		.CALIB_SAMPLES(CAL_FRAMES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.frm_valid(frm_valid),
		.frm_ready(frm_ready),
		.frm      (frm),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic void body_of_frame(input ifyu_pkg::frame_t f, output bit has,
		output ifyu_pkg::result_t w);
		ifyu_pkg::sample_t y;
		int                d;
		int                q;
		w = '0;
		has = f.frame_valid;
		if (!f.frame_valid)
			return;
		if (!cal_done) begin
			yaw_acc += int'($signed(f.yaw_raw));
			cal_seen++;
			if (cal_seen >= CAL_FRAMES) begin
				q = yaw_acc / cal_seen;
				if (yaw_acc < 0 && q * cal_seen != yaw_acc)
					q--;
				yaw_bias = 16'(q);
				prev_body = f.yaw_raw - yaw_bias;
				turns = 0;
				cal_done = 1'b1;
			end
			return;
		end
		y = f.yaw_raw - yaw_bias;
		d = int'(y) - int'(prev_body);
		if (d < -32768) begin
			if (turns < TURN_SAT)
				turns++;
		end else if (d > 32768) begin
			if (turns > -TURN_SAT)
				turns--;
		end
		prev_body = y;
		if (turns > turns_hi)
			turns_hi = turns;
		if (turns < turns_lo)
			turns_lo = turns;
		w.ready_res = 1'b1;
		w.body_roll = f.pitch_ang;
		w.body_pitch = f.roll_ang;
		w.body_yaw = y;
		w.body_rate_x = f.rate_y_raw;
		w.body_rate_y = f.rate_x_raw;
		w.body_rate_z = f.rate_z_raw;
		w.body_accel_x = f.accel_y_raw;
		w.body_accel_y = f.accel_x_raw;
		w.body_accel_z = f.accel_z_raw;
		w.temperature = f.die_temp;
		w.yaw_multi = turns * 65536 + int'(y);
	endfunction

	function automatic ifyu_pkg::frame_t random_frame(input ifyu_pkg::sample_t yaw);
		logic [191:0]     noise;
		ifyu_pkg::frame_t f;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		f = noise[160:0];
		f.frame_valid = ($urandom_range(0, 7) != 0);
		f.yaw_raw = yaw;
		return f;
	endfunction

	// raw yaw for the next frame once calibrated: full range, small steps, half-turn edges
	function automatic ifyu_pkg::sample_t pick_yaw();
		ifyu_pkg::sample_t body;
		case ($urandom_range(0, 3))
			0: body = 16'($urandom);
			1: body = prev_body + 16'($urandom_range(0, 4000)) - 16'd2000;
			2: body = prev_body + 16'h8000 + 16'($urandom_range(0, 4)) - 16'd2;
			default: begin
				case ($urandom_range(0, 3))
					0: body = 16'h7fff;
					1: body = 16'h8000;
					2: body = 16'h0000;
					default: body = 16'hffff;
				endcase
			end
		endcase
		return body + yaw_bias;
	endfunction

	task automatic offer(input ifyu_pkg::frame_t f);
		int gap;
		bit took;
		gap = pick_gap();
		if (gap > 0) begin
			frm_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frm_valid <= 1'b1;
		frm <= f;
		do begin
			@(negedge clk);
			took = frm_ready;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic feed(input ifyu_pkg::frame_t f, input bit zero_word);
		bit                has;
		ifyu_pkg::result_t w;
		offer(f);
		frames_taken++;
		body_of_frame(f, has, w);
		if (zero_word)
			w = '0;
		if (has)
			body_due.push_back(w);
		else
			frames_dropped++;
	endtask

	task automatic drain();
		frm_valid <= 1'b0;
		do
			@(posedge clk);
		while (body_due.size() != 0);
	endtask

	function automatic void check_field(input string nm, input longint ev, input longint av);
		if (ev != av) begin
			mismatches++;
			$display("%0t ns: %s expected %0d actual %0d", $time, nm, ev, av);
		end
	endfunction

	function automatic void compare_word(input ifyu_pkg::result_t e,
		input ifyu_pkg::result_t a);
		check_field("ready_res", e.ready_res, a.ready_res);
		check_field("body_roll", $signed(e.body_roll), $signed(a.body_roll));
		check_field("body_pitch", $signed(e.body_pitch), $signed(a.body_pitch));
		check_field("body_yaw", $signed(e.body_yaw), $signed(a.body_yaw));
		check_field("body_rate_x", $signed(e.body_rate_x), $signed(a.body_rate_x));
		check_field("body_rate_y", $signed(e.body_rate_y), $signed(a.body_rate_y));
		check_field("body_rate_z", $signed(e.body_rate_z), $signed(a.body_rate_z));
		check_field("body_accel_x", $signed(e.body_accel_x), $signed(a.body_accel_x));
		check_field("body_accel_y", $signed(e.body_accel_y), $signed(a.body_accel_y));
		check_field("body_accel_z", $signed(e.body_accel_z), $signed(a.body_accel_z));
		check_field("temperature", $signed(e.temperature), $signed(a.temperature));
		check_field("yaw_multi", $signed(e.yaw_multi), $signed(a.yaw_multi));
	endfunction

	// result side: random stalls, none while quiet
	always @(posedge clk) begin
		if (stall_left > 0) begin
			res_ready <= 1'b0;
			stall_left--;
		end else begin
			res_ready <= 1'b1;
			if (!quiet && $urandom_range(0, 5) == 0)
				stall_left = pick_gap();
		end
	end

	// sampled at the falling edge ahead of the edge that takes the word
	always @(negedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			words_checked++;
			if (body_due.size() == 0) begin
				mismatches++;
				$display("%0t ns: word with none expected, expected none actual %h",
					$time, res);
			end else begin
				compare_word(body_due.pop_front(), res);
			end
		end
	end

	always @(negedge clk) begin
		if ((frm_valid && frm_ready) || (res_valid && res_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("%0t ns: no word moved for %0d cycles", $time, idle_cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		ifyu_pkg::frame_t f;
		int               k;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_FILL) begin
				while (!cal_done)
					feed(random_frame(16'($urandom)), 1'b0);
			end else begin
				f.frame_valid = plan[i].valid;
				f.accel_x_raw = plan[i].base;
				f.accel_y_raw = ~plan[i].base;
				f.accel_z_raw = plan[i].base;
				f.rate_x_raw = ~plan[i].base;
				f.rate_y_raw = plan[i].base;
				f.rate_z_raw = ~plan[i].base;
				f.roll_ang = plan[i].base;
				f.pitch_ang = ~plan[i].base;
				f.yaw_raw = plan[i].yaw;
				if (plan[i].kind == ROW_BODY)
					f.yaw_raw = plan[i].yaw + yaw_bias;
				f.die_temp = plan[i].base;
				feed(f, plan[i].zero_word);
			end
		end

		k = 0;
		while (k < RAND_ITEMS) begin
			if (k % 100 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (k == RAND_ITEMS / 2)
				drain();
			f = random_frame(pick_yaw());
			feed(f, 1'b0);
			k++;
		end

		drain();
		repeat (12) @(posedge clk);
		$display("frames taken %0d (%0d invalid, dropped), words checked %0d, mismatches %0d",
			frames_taken, frames_dropped, words_checked, mismatches);
		$display("yaw offset %0d, turn count reached %0d and %0d",
			yaw_bias, turns_hi, turns_lo);
		if (mismatches == 0 && body_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
